// ===== src/band_covariance_matrix_unit_assert.svh =====
// Assertion macros shared by the band covariance RTL.
`ifndef BAND_COVARIANCE_MATRIX_UNIT_ASSERT_SVH
`define BAND_COVARIANCE_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define BCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define BCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bcm_pkg.sv =====
// Shared types and constants of the band covariance matrix unit.
package bcm_pkg;

    localparam int NUM_IN  = 8;    // band sample slots per pixel word
    localparam int SMP_W   = 16;   // sample field width
    localparam int BS_W    = 36;   // band sum width
    localparam int PS_W    = 52;   // pair product sum width
    localparam int CNT_W   = 21;   // pixel count width
    localparam int COV_W   = 41;   // Q32.8 covariance width
    localparam int D_W     = 42;   // n*(n-1) width
    localparam int MAG_W   = 73;   // |n*Sxy - Sx*Sy| width
    localparam int DIVD_W  = 81;   // scaled and rounded dividend width

    localparam int DEF_MAX_BANDS   = 8;
    localparam int DEF_MAX_PIXELS  = 1048576;
    localparam int DEF_SAMPLE_BITS = 16;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_FEW = 2'd1,
        STATUS_OVF = 2'd2
    } bcm_status_t;

    // Pixel handed from cell to cell.
    typedef struct packed {
        logic                         vld;
        logic [NUM_IN-1:0][SMP_W-1:0] smp;
    } bcm_link_t;

    // Operands of one matrix entry.
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [PS_W-1:0]  sxy;
        logic [BS_W-1:0]  sx;
        logic [BS_W-1:0]  sy;
    } bcm_ops_t;

endpackage

// ===== src/bcm_cell.sv =====
// One accumulator cell: the sum of its band and its row of band products.
module bcm_cell #(
    parameter int IDX       = 0,
    parameter int MAX_BANDS = bcm_pkg::DEF_MAX_BANDS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         clr,
    input  bcm_pkg::bcm_link_t                           link_i,
    output bcm_pkg::bcm_link_t                           link_o,
    output logic [bcm_pkg::BS_W-1:0]                     band_sum_o,
    output logic [bcm_pkg::NUM_IN-1:0][bcm_pkg::PS_W-1:0] pair_sum_o
);
    import bcm_pkg::*;

    bcm_link_t       link_reg;
    logic [BS_W-1:0] band_reg;

    // Pass the pixel on to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.vld <= 1'b0;
        end else begin
            link_reg.vld <= link_i.vld;
        end
        link_reg.smp <= link_i.smp;
    end

    // Band sum
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            band_reg <= '0;
        end else if (link_i.vld) begin
            band_reg <= band_reg + BS_W'(link_i.smp[IDX]);
        end
    end

    // Products with this band and every band at or above it
    for (genvar j = 0; j < NUM_IN; j++) begin : g_pair
        if (j >= IDX && j < MAX_BANDS) begin : g_used
            logic [PS_W-1:0]    pair_reg;
            logic [2*SMP_W-1:0] prod;

            assign prod = link_i.smp[IDX] * link_i.smp[j];

            always_ff @(posedge aclk) begin
                if (!aresetn || clr) begin
                    pair_reg <= '0;
                end else if (link_i.vld) begin
                    pair_reg <= pair_reg + PS_W'(prod);
                end
            end
            assign pair_sum_o[j] = pair_reg;
        end else begin : g_unused
            assign pair_sum_o[j] = '0;
        end
    end

    assign link_o     = link_reg;
    assign band_sum_o = band_reg;

endmodule

// ===== src/bcm_emit.sv =====
// Covariance entry unit: products, difference, rounding and a bit-serial divide.
module bcm_emit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  bcm_pkg::bcm_ops_t        ops,
    output logic                     done,
    output logic [bcm_pkg::COV_W-1:0] value
);
    import bcm_pkg::*;

    localparam int HALF_PS = PS_W / 2;
    localparam int HALF_BS = BS_W / 2;
    localparam int PA_W    = CNT_W + HALF_PS;
    localparam int PP_W    = 2 * HALF_BS;
    localparam int DC_W    = $clog2(DIVD_W);
    localparam logic [COV_W-1:0] COV_POS_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic [COV_W-1:0] COV_NEG_MIN = {1'b1, {(COV_W-1){1'b0}}};

    typedef enum logic [2:0] {
        E_IDLE, E_MUL, E_SUM, E_DIFF, E_PREP, E_DIV, E_SAT
    } emit_state_t;

    emit_state_t       state_reg;
    bcm_ops_t          ops_reg;
    logic [PA_W-1:0]   pa_reg, pb_reg;
    logic [PP_W-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [D_W-1:0]    d_reg;
    logic [MAG_W-1:0]  a_reg, b_reg, mag_reg;
    logic              neg_reg;
    logic [DIVD_W-1:0] q_reg;
    logic [D_W-1:0]    rem_reg;
    logic [DC_W-1:0]   bit_reg;
    logic [COV_W-1:0]  value_reg;
    logic              done_reg;

    logic [D_W-1:0]    trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg[D_W-2:0], q_reg[DIVD_W-1]};
    assign fits  = (trial >= d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        ops_reg   <= ops;
                        state_reg <= E_MUL;
                    end
                end
                // Partial products, each narrow enough for one multiplier
                E_MUL: begin
                    pa_reg  <= PA_W'(ops_reg.n) * PA_W'(ops_reg.sxy[HALF_PS-1:0]);
                    pb_reg  <= PA_W'(ops_reg.n) * PA_W'(ops_reg.sxy[PS_W-1:HALF_PS]);
                    p00_reg <= ops_reg.sx[HALF_BS-1:0] * ops_reg.sy[HALF_BS-1:0];
                    p01_reg <= ops_reg.sx[HALF_BS-1:0] * ops_reg.sy[BS_W-1:HALF_BS];
                    p10_reg <= ops_reg.sx[BS_W-1:HALF_BS] * ops_reg.sy[HALF_BS-1:0];
                    p11_reg <= ops_reg.sx[BS_W-1:HALF_BS] * ops_reg.sy[BS_W-1:HALF_BS];
                    d_reg   <= D_W'(ops_reg.n) * D_W'(ops_reg.n - CNT_W'(1));
                    state_reg <= E_SUM;
                end
                // n*Sxy and Sx*Sy
                E_SUM: begin
                    a_reg <= MAG_W'(pa_reg) + (MAG_W'(pb_reg) << HALF_PS);
                    b_reg <= MAG_W'(p00_reg) + (MAG_W'(p01_reg) << HALF_BS)
                           + (MAG_W'(p10_reg) << HALF_BS) + (MAG_W'(p11_reg) << (2*HALF_BS));
                    state_reg <= E_DIFF;
                end
                // Sign and magnitude of the difference
                E_DIFF: begin
                    if (a_reg >= b_reg) begin
                        neg_reg <= 1'b0;
                        mag_reg <= a_reg - b_reg;
                    end else begin
                        neg_reg <= 1'b1;
                        mag_reg <= b_reg - a_reg;
                    end
                    state_reg <= E_PREP;
                end
                // Scale by 256 and add half the divisor for round-to-nearest
                E_PREP: begin
                    q_reg     <= (DIVD_W'(mag_reg) << 8) + DIVD_W'(d_reg >> 1);
                    rem_reg   <= '0;
                    bit_reg   <= DC_W'(DIVD_W - 1);
                    state_reg <= E_DIV;
                end
                E_DIV: begin
                    rem_reg <= fits ? (trial - d_reg) : trial;
                    q_reg   <= {q_reg[DIVD_W-2:0], fits};
                    if (bit_reg == '0) begin
                        state_reg <= E_SAT;
                    end else begin
                        bit_reg <= bit_reg - DC_W'(1);
                    end
                end
                // Apply sign, saturate to the output range
                E_SAT: begin
                    if (neg_reg) begin
                        value_reg <= (q_reg > DIVD_W'(COV_NEG_MIN)) ? COV_NEG_MIN
                                                                   : -q_reg[COV_W-1:0];
                    end else begin
                        value_reg <= (q_reg > DIVD_W'(COV_POS_MAX)) ? COV_POS_MAX
                                                                   : q_reg[COV_W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// ===== src/band_covariance_matrix_unit.sv =====
// Band covariance matrix unit: accumulator cell chain, entry sequencer and config port.
//
// Pixels are taken one per clock, while accumulating, into a chain of MAX_BANDS
// accumulator cells; each pixel passes an input register and then moves one cell per cycle.
// After the pixel marked with tlast the input closes while the chain drains, then
// num_bands*num_bands entries are sent in row-major order. Entries with status ok go
// through the entry unit and its 81-step bit-serial divider; error entries skip it and
// carry a zero value. Once the final entry is taken all sums clear and the next image
// may start. m_tdata carries {row_band, col_band, cov_value} from the low bit up, with a
// zero pad on top; m_tuser is the status.
`include "band_covariance_matrix_unit_assert.svh"

module band_covariance_matrix_unit #(
    parameter int MAX_BANDS   = bcm_pkg::DEF_MAX_BANDS,
    parameter int MAX_PIXELS  = bcm_pkg::DEF_MAX_PIXELS,
    parameter int SAMPLE_BITS = bcm_pkg::DEF_SAMPLE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Pixel input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // sample_0 .. sample_7, 16 bits each
    input  logic         s_tlast,   // last_pixel
    // Matrix entries
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // row_band[2:0], col_band[5:3], cov_value[46:6], zero pad
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,   // last_entry
    // Register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import bcm_pkg::*;

    localparam int DR_W = $clog2(MAX_BANDS + 1);
    localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic REG_NUM_BANDS = 1'b0;

    typedef enum logic [2:0] {T_ACC, T_DRAIN, T_CALC, T_WAIT, T_OUT} top_state_t;

    top_state_t          state_reg;
    logic [3:0]          nb_cfg_reg;
    logic [3:0]          nb_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                ovf_reg;
    logic [DR_W-1:0]     drain_reg;
    bcm_status_t         status_reg;
    logic [2:0]          r_reg, c_reg;
    bcm_link_t           link_in_reg;
    logic [2:0]          row_reg, col_reg;
    logic [COV_W-1:0]    cov_reg;
    logic                last_reg;

    bcm_link_t                           link [MAX_BANDS];
    logic [NUM_IN-1:0][BS_W-1:0]         band_sum;
    logic [NUM_IN-1:0][NUM_IN-1:0][PS_W-1:0] pair_sum;

    logic                s_acc, m_acc, cfg_wr, room, clr;
    logic                emit_start, emit_done;
    logic [COV_W-1:0]    emit_value;
    bcm_ops_t            ops;
    logic [2:0]          lo_band, hi_band;
    logic [3:0]          nb_clamp;
    logic                row_end, col_end;

    assign s_tready = (state_reg == T_ACC);
    assign m_tvalid = (state_reg == T_OUT);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign room     = (cnt_reg < CNT_W'(MAX_PIXELS));
    assign clr      = m_acc && last_reg;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_NUM_BANDS) ? {28'd0, nb_cfg_reg} : 32'd0;

    // Band count clamped to 1..MAX_BANDS
    assign nb_clamp = (nb_cfg_reg == 4'd0) ? 4'd1 :
                      (nb_cfg_reg > 4'(MAX_BANDS)) ? 4'(MAX_BANDS) : nb_cfg_reg;
    assign col_end  = ({1'b0, c_reg} == nb_reg - 4'd1);
    assign row_end  = ({1'b0, r_reg} == nb_reg - 4'd1);

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_cfg_reg <= 4'd8;
        end else if (cfg_wr && paddr[2] == REG_NUM_BANDS) begin
            nb_cfg_reg <= pwdata[3:0];
        end
    end

    // Pixel entry into the cell chain; a pixel past the count limit is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_in_reg.vld <= 1'b0;
        end else begin
            link_in_reg.vld <= s_acc && room;
        end
        for (int i = 0; i < NUM_IN; i++) begin
            link_in_reg.smp[i] <= s_tdata[i*SMP_W +: SMP_W] & SMP_MASK;
        end
    end

    assign link[0] = link_in_reg;

    // Accumulator cells
    for (genvar i = 0; i < NUM_IN; i++) begin : g_cell
        if (i < MAX_BANDS) begin : g_on
            if (i < MAX_BANDS - 1) begin : g_mid
                bcm_cell #(.IDX(i), .MAX_BANDS(MAX_BANDS)) u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .clr        (clr),
                    .link_i     (link[i]),
                    .link_o     (link[i+1]),
                    .band_sum_o (band_sum[i]),
                    .pair_sum_o (pair_sum[i])
                );
            end else begin : g_end
                bcm_cell #(.IDX(i), .MAX_BANDS(MAX_BANDS)) u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .clr        (clr),
                    .link_i     (link[i]),
                    .link_o     (),
                    .band_sum_o (band_sum[i]),
                    .pair_sum_o (pair_sum[i])
                );
            end
        end else begin : g_off
            assign band_sum[i] = '0;
            assign pair_sum[i] = '0;
        end
    end

    // Operand selection for the current entry
    assign lo_band  = (r_reg < c_reg) ? r_reg : c_reg;
    assign hi_band  = (r_reg < c_reg) ? c_reg : r_reg;
    assign ops.n    = cnt_reg;
    assign ops.sxy  = pair_sum[lo_band][hi_band];
    assign ops.sx   = band_sum[r_reg];
    assign ops.sy   = band_sum[c_reg];
    assign emit_start = (state_reg == T_CALC) && (status_reg == STATUS_OK);

    bcm_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (emit_start),
        .ops     (ops),
        .done    (emit_done),
        .value   (emit_value)
    );

    // Frame sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_ACC;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            case (state_reg)
                T_ACC: begin
                    if (s_acc) begin
                        if (room) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            drain_reg <= DR_W'(MAX_BANDS);
                            state_reg <= T_DRAIN;
                        end
                    end
                end
                T_DRAIN: begin
                    if (drain_reg == '0) begin
                        r_reg  <= '0;
                        c_reg  <= '0;
                        nb_reg <= nb_clamp;
                        status_reg <= ovf_reg ? STATUS_OVF :
                                      (cnt_reg < CNT_W'(2)) ? STATUS_FEW : STATUS_OK;
                        state_reg <= T_CALC;
                    end else begin
                        drain_reg <= drain_reg - DR_W'(1);
                    end
                end
                T_CALC: begin
                    row_reg  <= r_reg;
                    col_reg  <= c_reg;
                    last_reg <= row_end && col_end;
                    if (status_reg == STATUS_OK) begin
                        state_reg <= T_WAIT;
                    end else begin
                        cov_reg   <= '0;
                        state_reg <= T_OUT;
                    end
                end
                T_WAIT: begin
                    if (emit_done) begin
                        cov_reg   <= emit_value;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_acc) begin
                        if (last_reg) begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= T_ACC;
                        end else begin
                            if (col_end) begin
                                c_reg <= '0;
                                r_reg <= r_reg + 3'd1;
                            end else begin
                                c_reg <= c_reg + 3'd1;
                            end
                            state_reg <= T_CALC;
                        end
                    end
                end
                default: begin
                    state_reg <= T_ACC;
                end
            endcase
        end
    end

    assign m_tdata = {1'b0, cov_reg, col_reg, row_reg};
    assign m_tuser = status_reg;
    assign m_tlast = last_reg;

    // Checks
    `BCM_ASSERT_IMP(a_one_side_open, s_tready, !m_tvalid, "input open while an entry is shown")
    `BCM_ASSERT_IMP(a_start_only_ok, emit_start, status_reg == STATUS_OK, "entry math on error")
    `BCM_ASSERT_NXT(a_clear_after_frame, m_acc && m_tlast, cnt_reg == '0 && !ovf_reg, "count kept")

endmodule
